// ===== hw/rtl/ifsfern_pkg.sv =====
// ----------------------------------------------------------------------------
// ifsfern_pkg
// Shared types and constants of the fern point generator: field widths,
// fixed map coefficients, screen scaling constants and register codes.
// ----------------------------------------------------------------------------
package ifsfern_pkg;

   // Field widths
   localparam int BYTE_W   = 8;
   localparam int COEF_W   = 16;
   localparam int POS_W    = 24;
   localparam int PIX_W    = 14;
   localparam int ACC_W    = 41;   // sum of two 16x24 signed products
   localparam int WIDE_W   = 42;   // rounding and screen numerators
   localparam int MUL_A_W  = COEF_W;
   localparam int MUL_B_W  = POS_W;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int FRAC_BITS = 12;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = COEF_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEF_MAP1_A = 3'd0,
      CSR_COEF_MAP1_B = 3'd1,
      CSR_COEF_MAP2_A = 3'd2,
      CSR_COEF_MAP2_B = 3'd3,
      CSR_COEF_MAP3_B = 3'd4,
      CSR_THR_MAP0    = 3'd5,
      CSR_THR_MAP1    = 3'd6,
      CSR_THR_MAP2    = 3'd7
   } csr_addr_type;

   localparam logic signed [COEF_W-1:0] RST_MAP1_A = 16'sd819;
   localparam logic signed [COEF_W-1:0] RST_MAP1_B = -16'sd1065;
   localparam logic signed [COEF_W-1:0] RST_MAP2_A = -16'sd614;
   localparam logic signed [COEF_W-1:0] RST_MAP2_B = 16'sd1147;
   localparam logic signed [COEF_W-1:0] RST_MAP3_B = 16'sd164;
   localparam logic [BYTE_W-1:0] RST_THR_MAP0 = 8'd2;
   localparam logic [BYTE_W-1:0] RST_THR_MAP1 = 8'd20;
   localparam logic [BYTE_W-1:0] RST_THR_MAP2 = 8'd38;

   typedef struct packed {
      logic signed [COEF_W-1:0] map1_a;
      logic signed [COEF_W-1:0] map1_b;
      logic signed [COEF_W-1:0] map2_a;
      logic signed [COEF_W-1:0] map2_b;
      logic signed [COEF_W-1:0] map3_b;
      logic [BYTE_W-1:0]        thr_map0;
      logic [BYTE_W-1:0]        thr_map1;
      logic [BYTE_W-1:0]        thr_map2;
   } csr_regs_type;

   // Fixed Q3.12 coefficients
   localparam logic signed [COEF_W-1:0] MAP0_D = 16'sd655;
   localparam logic signed [COEF_W-1:0] MAP1_C = 16'sd942;
   localparam logic signed [COEF_W-1:0] MAP1_D = 16'sd901;
   localparam logic signed [COEF_W-1:0] MAP1_F = 16'sd6554;
   localparam logic signed [COEF_W-1:0] MAP2_C = 16'sd1065;
   localparam logic signed [COEF_W-1:0] MAP2_D = 16'sd983;
   localparam logic signed [COEF_W-1:0] MAP2_F = 16'sd1802;
   localparam logic signed [COEF_W-1:0] MAP3_A = 16'sd3482;
   localparam logic signed [COEF_W-1:0] MAP3_C = -16'sd164;
   localparam logic signed [COEF_W-1:0] MAP3_D = 16'sd3482;
   localparam logic signed [COEF_W-1:0] MAP3_F = 16'sd6554;

   typedef enum logic [1:0] {
      MAP0 = 2'd0,
      MAP1 = 2'd1,
      MAP2 = 2'd2,
      MAP3 = 2'd3
   } map_type;

   // Screen scaling: pixel = trunc(pos * H / (13 * 4096)) with offsets
   localparam int SCREEN_WIDTH  = 1920;
   localparam int SCREEN_HEIGHT = 1080;
   localparam int PIX_DIV       = 13;
   localparam longint DEN       = PIX_DIV * (2 ** FRAC_BITS);
   localparam logic signed [WIDE_W-1:0] HALF_W_DEN = WIDE_W'((SCREEN_WIDTH / 2) * DEN);
   localparam logic signed [WIDE_W-1:0] H_DEN      = WIDE_W'(SCREEN_HEIGHT * DEN);
   localparam logic signed [MUL_A_W-1:0] SCREEN_H_OP = MUL_A_W'(SCREEN_HEIGHT);

   // Quotient of pos*H/4096 by 13; clamp keeps it where saturation is certain
   localparam int PIX_LIM     = 2 ** (PIX_W - 1);
   localparam int NQ_W        = 17;
   localparam int NQ_CLAMP    = PIX_DIV * (PIX_LIM + 1);
   localparam int RECIP_SHIFT = NQ_W + 1;
   localparam int RECIP       = (2 ** RECIP_SHIFT) / PIX_DIV;
   localparam logic signed [MUL_A_W-1:0] RECIP_OP = MUL_A_W'(RECIP);

   localparam logic signed [PIX_W-1:0] PIX_MAX = PIX_W'(PIX_LIM - 1);
   localparam logic signed [PIX_W-1:0] PIX_MIN = PIX_W'(-PIX_LIM);

   localparam logic signed [WIDE_W-1:0] POS_MAX_W = WIDE_W'((2 ** (POS_W - 1)) - 1);
   localparam logic signed [WIDE_W-1:0] POS_MIN_W = -WIDE_W'(2 ** (POS_W - 1));

   // Shared multiply-accumulate control
   typedef struct packed {
      logic                      en;
      logic                      clear;
      logic signed [MUL_A_W-1:0] op_a;
      logic signed [MUL_B_W-1:0] op_b;
   } mac_ctrl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_AX,
      ST_BY,
      ST_DY,
      ST_CX,
      ST_HX,
      ST_HY,
      ST_MX,
      ST_MY,
      ST_DONE
   } state_type;

endpackage

// ===== hw/rtl/ifsfern_req_if.sv =====
// ----------------------------------------------------------------------------
// ifsfern_req_if
// Step request channel: random byte and restart flag.
// ----------------------------------------------------------------------------
interface ifsfern_req_if;
   logic                           valid;
   logic                           ready;
   logic [ifsfern_pkg::BYTE_W-1:0] rnd_byte;
   logic                           restart;

   modport source (output valid, rnd_byte, restart, input ready);
   modport sink   (input valid, rnd_byte, restart, output ready);
endinterface

// ===== hw/rtl/ifsfern_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ifsfern_rsp_if
// Point result channel: position, screen pixel, visibility and map index.
// ----------------------------------------------------------------------------
interface ifsfern_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [ifsfern_pkg::POS_W-1:0] pos_x;
   logic signed [ifsfern_pkg::POS_W-1:0] pos_y;
   logic signed [ifsfern_pkg::PIX_W-1:0] pixel_x;
   logic signed [ifsfern_pkg::PIX_W-1:0] pixel_y;
   logic                                 on_screen;
   logic [1:0]                           map_used;

   modport source (output valid, pos_x, pos_y, pixel_x, pixel_y, on_screen, map_used,
                   input ready);
   modport sink   (input valid, pos_x, pos_y, pixel_x, pixel_y, on_screen, map_used,
                   output ready);
endinterface

// ===== hw/rtl/ifs_fern_point_generator.sv =====
// ----------------------------------------------------------------------------
// ifs_fern_point_generator
// One chaos-game step of a four-map fern per request beat.
//
//   channel  dir  payload                                          handshake
//   req_ch   in   rnd_byte[7:0], restart                           valid/ready
//   rsp_ch   out  pos_x, pos_y, pixel_x, pixel_y, on_screen, map   valid/ready
//   csr_*    in   csr_index[2:0], csr_wdata[15:0]                  csr_we only
//
// A step makes eight passes through the shared 16x24 multiply-accumulate
// (two per coordinate, two for screen scaling, two for the divide-by-13
// reciprocal), then loads the result register in its last state and returns
// to idle, where the next beat is taken.
// A full result register that is not taken holds the sequencer in its last
// step; once it is loaded a new request is taken while it still waits.
// Reset is synchronous: registers return to their defaults, position to 0.
// ----------------------------------------------------------------------------
module ifs_fern_point_generator (
   input  logic                                clock,
   input  logic                                reset,
   ifsfern_req_if.sink                         req_ch,
   ifsfern_rsp_if.source                       rsp_ch,
   input  logic                                csr_we,
   input  logic [ifsfern_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ifsfern_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   ifsfern_pkg::csr_regs_type             regs;
   ifsfern_pkg::mac_ctrl_type             mac_ctrl;
   logic signed [ifsfern_pkg::ACC_W-1:0]  acc;

   ifsfern_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .regs      (regs)
   );

   ifsfern_mac u_mac (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .acc   (acc)
   );

   ifsfern_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch),
      .regs     (regs),
      .mac_ctrl (mac_ctrl),
      .acc      (acc)
   );

endmodule

// ===== hw/rtl/ifsfern_csr.sv =====
// ----------------------------------------------------------------------------
// ifsfern_csr
// Coefficient and threshold registers behind the plain write port.
// ----------------------------------------------------------------------------
module ifsfern_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [ifsfern_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ifsfern_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output ifsfern_pkg::csr_regs_type           regs
);

   ifsfern_pkg::csr_regs_type regs_ff;
   ifsfern_pkg::csr_regs_type regs_in;

   always_comb begin
      regs_in = regs_ff;
      if (csr_we) begin
         case (ifsfern_pkg::csr_addr_type'(csr_index))
            ifsfern_pkg::CSR_COEF_MAP1_A: regs_in.map1_a = csr_wdata;
            ifsfern_pkg::CSR_COEF_MAP1_B: regs_in.map1_b = csr_wdata;
            ifsfern_pkg::CSR_COEF_MAP2_A: regs_in.map2_a = csr_wdata;
            ifsfern_pkg::CSR_COEF_MAP2_B: regs_in.map2_b = csr_wdata;
            ifsfern_pkg::CSR_COEF_MAP3_B: regs_in.map3_b = csr_wdata;
            ifsfern_pkg::CSR_THR_MAP0:    regs_in.thr_map0 = csr_wdata[ifsfern_pkg::BYTE_W-1:0];
            ifsfern_pkg::CSR_THR_MAP1:    regs_in.thr_map1 = csr_wdata[ifsfern_pkg::BYTE_W-1:0];
            ifsfern_pkg::CSR_THR_MAP2:    regs_in.thr_map2 = csr_wdata[ifsfern_pkg::BYTE_W-1:0];
            default:                      regs_in = regs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.map1_a   <= ifsfern_pkg::RST_MAP1_A;
         regs_ff.map1_b   <= ifsfern_pkg::RST_MAP1_B;
         regs_ff.map2_a   <= ifsfern_pkg::RST_MAP2_A;
         regs_ff.map2_b   <= ifsfern_pkg::RST_MAP2_B;
         regs_ff.map3_b   <= ifsfern_pkg::RST_MAP3_B;
         regs_ff.thr_map0 <= ifsfern_pkg::RST_THR_MAP0;
         regs_ff.thr_map1 <= ifsfern_pkg::RST_THR_MAP1;
         regs_ff.thr_map2 <= ifsfern_pkg::RST_THR_MAP2;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign regs = regs_ff;

endmodule

// ===== hw/rtl/ifsfern_mac.sv =====
// ----------------------------------------------------------------------------
// ifsfern_mac
// Shared 16x24 signed multiply-accumulate unit with a registered accumulator.
// ----------------------------------------------------------------------------
module ifsfern_mac (
   input  logic                                    clock,
   input  ifsfern_pkg::mac_ctrl_type               ctrl,
   output logic signed [ifsfern_pkg::ACC_W-1:0]    acc
);

   logic signed [ifsfern_pkg::MUL_A_W-1:0] op_a;
   logic signed [ifsfern_pkg::MUL_B_W-1:0] op_b;
   logic signed [ifsfern_pkg::PROD_W-1:0]  prod;
   logic signed [ifsfern_pkg::ACC_W-1:0]   base;
   logic signed [ifsfern_pkg::ACC_W-1:0]   acc_ff;
   logic signed [ifsfern_pkg::ACC_W-1:0]   acc_in;

   assign op_a   = ctrl.op_a;
   assign op_b   = ctrl.op_b;
   assign prod   = op_a * op_b;
   assign base   = ctrl.clear ? '0 : acc_ff;
   assign acc_in = base + {prod[ifsfern_pkg::PROD_W-1], prod};

   // hold the accumulator while the sequencer waits
   always_ff @(posedge clock) begin
      if (ctrl.en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

// ===== hw/rtl/ifsfern_seq.sv =====
// ----------------------------------------------------------------------------
// ifsfern_seq
// Step sequencer: map choice, operand steering into the shared MAC, rounding,
// saturation, screen scaling by reciprocal and the result register.
// ----------------------------------------------------------------------------
module ifsfern_seq (
   input  logic                                   clock,
   input  logic                                   reset,
   ifsfern_req_if.sink                            req_ch,
   ifsfern_rsp_if.source                          rsp_ch,
   input  ifsfern_pkg::csr_regs_type              regs,
   output ifsfern_pkg::mac_ctrl_type              mac_ctrl,
   input  logic signed [ifsfern_pkg::ACC_W-1:0]   acc
);

   localparam int QW = ifsfern_pkg::PIX_W;

   // round half up from Q.24 to Q.12
   function automatic logic signed [ifsfern_pkg::WIDE_W-1:0] round12(
      input logic signed [ifsfern_pkg::ACC_W-1:0] v);
      logic signed [ifsfern_pkg::WIDE_W-1:0] t;
      t = $signed({v[ifsfern_pkg::ACC_W-1], v}) + 42'sd2048;
      return t >>> ifsfern_pkg::FRAC_BITS;
   endfunction

   function automatic logic signed [ifsfern_pkg::POS_W-1:0] sat_pos(
      input logic signed [ifsfern_pkg::WIDE_W-1:0] v);
      logic signed [ifsfern_pkg::WIDE_W-1:0] t;
      t = v;
      if (v > ifsfern_pkg::POS_MAX_W) begin
         t = ifsfern_pkg::POS_MAX_W;
      end else if (v < ifsfern_pkg::POS_MIN_W) begin
         t = ifsfern_pkg::POS_MIN_W;
      end
      return t[ifsfern_pkg::POS_W-1:0];
   endfunction

   // magnitude of the numerator over 4096, clamped where saturation is sure
   function automatic logic [ifsfern_pkg::NQ_W-1:0] mag_clamp(
      input logic signed [ifsfern_pkg::WIDE_W-1:0] num);
      logic [ifsfern_pkg::WIDE_W-1:0]                       m;
      logic [ifsfern_pkg::WIDE_W-ifsfern_pkg::FRAC_BITS-1:0] sh;
      m  = num[ifsfern_pkg::WIDE_W-1] ? ifsfern_pkg::WIDE_W'(-num) : num;
      sh = m[ifsfern_pkg::WIDE_W-1:ifsfern_pkg::FRAC_BITS];
      if (sh > (ifsfern_pkg::WIDE_W-ifsfern_pkg::FRAC_BITS)'(ifsfern_pkg::NQ_CLAMP)) begin
         return ifsfern_pkg::NQ_W'(ifsfern_pkg::NQ_CLAMP);
      end
      return sh[ifsfern_pkg::NQ_W-1:0];
   endfunction

   // quotient by 13 from the reciprocal product, one correction, sign, saturate
   function automatic logic signed [ifsfern_pkg::PIX_W-1:0] pix_finish(
      input logic signed [ifsfern_pkg::ACC_W-1:0] p,
      input logic [ifsfern_pkg::NQ_W-1:0]         n,
      input logic                                 neg);
      logic [QW-1:0]                q0;
      logic [QW-1:0]                q;
      logic [ifsfern_pkg::NQ_W:0]   q0x;
      logic [ifsfern_pkg::NQ_W:0]   r;
      q0  = p[ifsfern_pkg::RECIP_SHIFT +: QW];
      q0x = {{(ifsfern_pkg::NQ_W+1-QW){1'b0}}, q0};
      r   = {1'b0, n} - ((q0x << 3) + (q0x << 2) + q0x);
      q   = (r >= (ifsfern_pkg::NQ_W+1)'(ifsfern_pkg::PIX_DIV)) ? q0 + 1'b1 : q0;
      if (neg) begin
         if (q > QW'(ifsfern_pkg::PIX_LIM)) begin
            return ifsfern_pkg::PIX_MIN;
         end
         return QW'(-$signed({1'b0, q}));
      end
      if (q >= QW'(ifsfern_pkg::PIX_LIM)) begin
         return ifsfern_pkg::PIX_MAX;
      end
      return $signed(q);
   endfunction

   ifsfern_pkg::state_type state_ff, state_in;

   ifsfern_pkg::map_type map_ff, map_sel;
   logic signed [ifsfern_pkg::POS_W-1:0]  cur_x_ff, cur_y_ff;
   logic signed [ifsfern_pkg::POS_W-1:0]  nx_ff, ny_ff, nx_in, ny_in;
   logic [ifsfern_pkg::NQ_W-1:0]          nqx_ff, nqy_ff;
   logic                                  negx_ff, negy_ff;
   logic signed [ifsfern_pkg::PIX_W-1:0]  px_ff, px_in, py_in;
   logic signed [ifsfern_pkg::WIDE_W-1:0] rnd, num_x, num_y, f_ext;

   logic signed [ifsfern_pkg::COEF_W-1:0] coef_a, coef_b, coef_c, coef_d, coef_f;

   logic rsp_valid_ff;
   logic signed [ifsfern_pkg::POS_W-1:0] rsp_pos_x_ff, rsp_pos_y_ff;
   logic signed [ifsfern_pkg::PIX_W-1:0] rsp_pixel_x_ff, rsp_pixel_y_ff;
   logic                                 rsp_on_screen_ff;
   logic [1:0]                           rsp_map_used_ff;

   logic req_fire, out_free;
   logic nx_ld, ny_ld, nqx_ld, nqy_ld, px_ld, out_ld;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // first threshold the byte does not exceed picks the map
   always_comb begin
      if (req_ch.rnd_byte <= regs.thr_map0) begin
         map_sel = ifsfern_pkg::MAP0;
      end else if (req_ch.rnd_byte <= regs.thr_map1) begin
         map_sel = ifsfern_pkg::MAP1;
      end else if (req_ch.rnd_byte <= regs.thr_map2) begin
         map_sel = ifsfern_pkg::MAP2;
      end else begin
         map_sel = ifsfern_pkg::MAP3;
      end
   end

   always_comb begin
      case (map_ff)
         ifsfern_pkg::MAP0: begin
            coef_a = '0;
            coef_b = '0;
            coef_c = '0;
            coef_d = ifsfern_pkg::MAP0_D;
            coef_f = '0;
         end
         ifsfern_pkg::MAP1: begin
            coef_a = regs.map1_a;
            coef_b = regs.map1_b;
            coef_c = ifsfern_pkg::MAP1_C;
            coef_d = ifsfern_pkg::MAP1_D;
            coef_f = ifsfern_pkg::MAP1_F;
         end
         ifsfern_pkg::MAP2: begin
            coef_a = regs.map2_a;
            coef_b = regs.map2_b;
            coef_c = ifsfern_pkg::MAP2_C;
            coef_d = ifsfern_pkg::MAP2_D;
            coef_f = ifsfern_pkg::MAP2_F;
         end
         default: begin
            coef_a = ifsfern_pkg::MAP3_A;
            coef_b = regs.map3_b;
            coef_c = ifsfern_pkg::MAP3_C;
            coef_d = ifsfern_pkg::MAP3_D;
            coef_f = ifsfern_pkg::MAP3_F;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ifsfern_pkg::ST_IDLE: if (req_fire) state_in = ifsfern_pkg::ST_AX;
         ifsfern_pkg::ST_AX:   state_in = ifsfern_pkg::ST_BY;
         ifsfern_pkg::ST_BY:   state_in = ifsfern_pkg::ST_DY;
         ifsfern_pkg::ST_DY:   state_in = ifsfern_pkg::ST_CX;
         ifsfern_pkg::ST_CX:   state_in = ifsfern_pkg::ST_HX;
         ifsfern_pkg::ST_HX:   state_in = ifsfern_pkg::ST_HY;
         ifsfern_pkg::ST_HY:   state_in = ifsfern_pkg::ST_MX;
         ifsfern_pkg::ST_MX:   state_in = ifsfern_pkg::ST_MY;
         ifsfern_pkg::ST_MY:   state_in = ifsfern_pkg::ST_DONE;
         ifsfern_pkg::ST_DONE: if (out_free) state_in = ifsfern_pkg::ST_IDLE;
         default:              state_in = ifsfern_pkg::ST_IDLE;
      endcase
   end

   // outputs: each MAC step issues one product; DY, HX, HY, MX, MY and DONE retire the previous one
   always_comb begin
      mac_ctrl     = '0;
      req_ch.ready = 1'b0;
      nx_ld  = 1'b0;
      ny_ld  = 1'b0;
      nqx_ld = 1'b0;
      nqy_ld = 1'b0;
      px_ld  = 1'b0;
      out_ld = 1'b0;
      case (state_ff)
         ifsfern_pkg::ST_IDLE: begin
            req_ch.ready = 1'b1;
         end
         ifsfern_pkg::ST_AX: begin
            mac_ctrl = '{en: 1'b1, clear: 1'b1, op_a: coef_a, op_b: cur_x_ff};
         end
         ifsfern_pkg::ST_BY: begin
            mac_ctrl = '{en: 1'b1, clear: 1'b0, op_a: coef_b, op_b: cur_y_ff};
         end
         ifsfern_pkg::ST_DY: begin
            nx_ld    = 1'b1;
            mac_ctrl = '{en: 1'b1, clear: 1'b1, op_a: coef_d, op_b: cur_y_ff};
         end
         ifsfern_pkg::ST_CX: begin
            mac_ctrl = '{en: 1'b1, clear: 1'b0, op_a: coef_c, op_b: nx_ff};
         end
         ifsfern_pkg::ST_HX: begin
            ny_ld    = 1'b1;
            mac_ctrl = '{en: 1'b1, clear: 1'b1, op_a: ifsfern_pkg::SCREEN_H_OP, op_b: nx_ff};
         end
         ifsfern_pkg::ST_HY: begin
            nqx_ld   = 1'b1;
            mac_ctrl = '{en: 1'b1, clear: 1'b1, op_a: ifsfern_pkg::SCREEN_H_OP, op_b: ny_ff};
         end
         ifsfern_pkg::ST_MX: begin
            nqy_ld   = 1'b1;
            mac_ctrl = '{en: 1'b1, clear: 1'b1, op_a: ifsfern_pkg::RECIP_OP,
                         op_b: ifsfern_pkg::MUL_B_W'(nqx_ff)};
         end
         ifsfern_pkg::ST_MY: begin
            px_ld    = 1'b1;
            mac_ctrl = '{en: 1'b1, clear: 1'b1, op_a: ifsfern_pkg::RECIP_OP,
                         op_b: ifsfern_pkg::MUL_B_W'(nqy_ff)};
         end
         ifsfern_pkg::ST_DONE: begin
            out_ld = out_free;
         end
         default: begin
            mac_ctrl = '0;
         end
      endcase
   end

   assign rnd   = round12(acc);
   assign f_ext = {{(ifsfern_pkg::WIDE_W-ifsfern_pkg::COEF_W){coef_f[ifsfern_pkg::COEF_W-1]}},
                   coef_f};
   assign nx_in = sat_pos(rnd);
   assign ny_in = sat_pos(rnd + f_ext);
   assign num_x = $signed({acc[ifsfern_pkg::ACC_W-1], acc}) + ifsfern_pkg::HALF_W_DEN;
   assign num_y = ifsfern_pkg::H_DEN - $signed({acc[ifsfern_pkg::ACC_W-1], acc});
   assign px_in = pix_finish(acc, nqx_ff, negx_ff);
   assign py_in = pix_finish(acc, nqy_ff, negy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ifsfern_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (out_ld) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (req_fire && req_ch.restart) begin
            cur_x_ff <= '0;
            cur_y_ff <= '0;
         end else if (out_ld) begin
            cur_x_ff <= nx_ff;
            cur_y_ff <= ny_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) map_ff <= map_sel;
      if (nx_ld)    nx_ff  <= nx_in;
      if (ny_ld)    ny_ff  <= ny_in;
      if (nqx_ld) begin
         nqx_ff  <= mag_clamp(num_x);
         negx_ff <= num_x[ifsfern_pkg::WIDE_W-1];
      end
      if (nqy_ld) begin
         nqy_ff  <= mag_clamp(num_y);
         negy_ff <= num_y[ifsfern_pkg::WIDE_W-1];
      end
      if (px_ld) px_ff <= px_in;
      if (out_ld) begin
         rsp_pos_x_ff     <= nx_ff;
         rsp_pos_y_ff     <= ny_ff;
         rsp_pixel_x_ff   <= px_ff;
         rsp_pixel_y_ff   <= py_in;
         rsp_on_screen_ff <= !px_ff[QW-1] && (px_ff < QW'(ifsfern_pkg::SCREEN_WIDTH)) &&
                             !py_in[QW-1] && (py_in < QW'(ifsfern_pkg::SCREEN_HEIGHT));
         rsp_map_used_ff  <= map_ff;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.pos_x     = rsp_pos_x_ff;
   assign rsp_ch.pos_y     = rsp_pos_y_ff;
   assign rsp_ch.pixel_x   = rsp_pixel_x_ff;
   assign rsp_ch.pixel_y   = rsp_pixel_y_ff;
   assign rsp_ch.on_screen = rsp_on_screen_ff;
   assign rsp_ch.map_used  = rsp_map_used_ff;

   a_fire_starts_step: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ifsfern_pkg::ST_AX)
      else $error("accepted beat did not start the step sequence");

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_ch.restart |=> cur_x_ff == '0 && cur_y_ff == '0)
      else $error("restart did not clear the position");

   a_map0_x_zero: assert property (@(posedge clock) disable iff (reset)
      out_ld && map_ff == ifsfern_pkg::MAP0 |=> rsp_pos_x_ff == '0)
      else $error("map 0 produced nonzero x");

   a_sat_off_screen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_pixel_x_ff == ifsfern_pkg::PIX_MAX ||
                       rsp_pixel_x_ff == ifsfern_pkg::PIX_MIN) |-> !rsp_on_screen_ff)
      else $error("saturated pixel flagged on screen");

endmodule
